@@ rtl/sv39ptw_pkg.sv @@
// Shared constants for the Sv39 page-table walker.
`default_nettype none

package sv39ptw_pkg;

    localparam int OP_W       = 2;
    localparam int VA_W       = 64;
    localparam int PA_W       = 56;
    localparam int PPN_W      = 44;
    localparam int SLOT_W     = 12;
    localparam int ENTRY_W    = 64;
    localparam int STATUS_W   = 3;
    localparam int IDX_W      = 9;
    localparam int OFFSET_W   = 12;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 64;

    localparam int LEVELS        = 3;
    localparam int PAGE_ENTRIES  = 512;
    localparam int VA_LIMIT_BIT  = 38;
    localparam int VA_KEEP_W     = OFFSET_W + (LEVELS - 1) * IDX_W;

    localparam int PTE_V       = 0;
    localparam int PTE_U       = 4;
    localparam int PTE_PPN_LSB = 10;

    localparam logic [OP_W-1:0] OP_WRITE         = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP_USER   = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP_ANY    = 2'd2;
    localparam logic [OP_W-1:0] OP_LOOKUP_OFFSET = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE  = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_MAPPED = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOT_USER   = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_OUTSIDE    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_PPN       = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STORE_BASE_PPN = 4'd1;

endpackage

`default_nettype wire

@@ rtl/sv39ptw_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module sv39ptw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/sv39_page_table_walker.sv @@
// Sv39 page-table walker over a local table store held in a synchronous RAM.
// A write transaction gives done in the cycle after acceptance; busy stays low, one per cycle.
// A full lookup makes one dependent read of the table RAM per level, then registers the result;
// a failure before the first read gives done in the cycle after acceptance, one on a read ends the walk there.
// After reset the RAM is cleared one entry per cycle, all TABLE_PAGES*512 entries, with busy high.
// done is a one-cycle strobe the receiver cannot stall; a new item may start in its cycle.
`default_nettype none

module sv39_page_table_walker #(
    parameter int TABLE_PAGES = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [sv39ptw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sv39ptw_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [sv39ptw_pkg::OP_W-1:0]          op,
    input  logic [sv39ptw_pkg::VA_W-1:0]          vaddr,
    input  logic [sv39ptw_pkg::SLOT_W-1:0]        entry_slot,
    input  logic [sv39ptw_pkg::ENTRY_W-1:0]       entry_value,
    output logic                                  done,
    output logic [sv39ptw_pkg::PA_W-1:0]          phys_addr,
    output logic [sv39ptw_pkg::STATUS_W-1:0]      status
);

    import sv39ptw_pkg::*;

    localparam int DEPTH  = TABLE_PAGES * PAGE_ENTRIES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PAGE_W = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_CLEAR = 3'b010,
        ST_WALK  = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [1:0]             level_reg, level_next;
    logic [OP_W-1:0]        op_reg, op_next;
    logic [VA_KEEP_W-1:0]   va_reg, va_next;
    logic [ADDR_W-1:0]      clr_reg, clr_next;
    logic                   done_reg, done_next;
    logic [PA_W-1:0]        pa_reg, pa_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [PPN_W-1:0]       root_ppn_reg;
    logic [PPN_W-1:0]       store_base_ppn_reg;

    logic                   accept;
    logic [PPN_W-1:0]       chk_ppn;
    logic [PPN_W-1:0]       page_diff;
    logic                   in_store;
    logic [IDX_W-1:0]       rd_idx;
    logic [PAGE_W+IDX_W-1:0] rd_addr_full;
    logic [31:0]            slot_ext;
    logic                   slot_in;
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [ENTRY_W-1:0]     ram_wdata;
    logic [ADDR_W-1:0]      ram_raddr;
    logic [ENTRY_W-1:0]     ram_rdata;

    assign cfg_ready = 1'b1;
    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign done      = done_reg;
    assign phys_addr = pa_reg;
    assign status    = status_reg;

    // The range check serves the root table at acceptance and each next table during the walk.
    assign chk_ppn   = (state_reg == ST_WALK) ? ram_rdata[PTE_PPN_LSB +: PPN_W] : root_ppn_reg;
    assign page_diff = chk_ppn - store_base_ppn_reg;
    assign in_store  = (chk_ppn >= store_base_ppn_reg) && (page_diff < PPN_W'(TABLE_PAGES));

    always_comb
    begin
        if (state_reg == ST_WALK)
        begin
            if (level_reg == 2'd2)
            begin
                rd_idx = va_reg[OFFSET_W + IDX_W +: IDX_W];
            end
            else
            begin
                rd_idx = va_reg[OFFSET_W +: IDX_W];
            end
        end
        else
        begin
            rd_idx = vaddr[OFFSET_W + 2 * IDX_W +: IDX_W];
        end
    end

    assign rd_addr_full = {page_diff[PAGE_W-1:0], rd_idx};
    assign ram_raddr    = rd_addr_full[ADDR_W-1:0];

    assign slot_ext = 32'(entry_slot);
    assign slot_in  = slot_ext < 32'(DEPTH);

    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = accept && (op == OP_WRITE) && slot_in;
            ram_waddr = slot_ext[ADDR_W-1:0];
            ram_wdata = entry_value;
        end
    end

    sv39ptw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next  = state_reg;
        level_next  = level_reg;
        op_next     = op_reg;
        va_next     = va_reg;
        clr_next    = clr_reg;
        done_next   = 1'b0;
        pa_next     = pa_reg;
        status_next = status_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next    = op;
                    va_next    = vaddr[VA_KEEP_W-1:0];
                    level_next = 2'(LEVELS - 1);
                    pa_next    = '0;
                    if (op == OP_WRITE)
                    begin
                        done_next   = 1'b1;
                        status_next = STATUS_OK;
                    end
                    else if (vaddr[VA_W-1:VA_LIMIT_BIT] != '0)
                    begin
                        done_next   = 1'b1;
                        status_next = STATUS_TOO_LARGE;
                    end
                    else if (!in_store)
                    begin
                        done_next   = 1'b1;
                        status_next = STATUS_OUTSIDE;
                    end
                    else
                    begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_WALK:
            begin
                pa_next = '0;
                if (!ram_rdata[PTE_V])
                begin
                    done_next   = 1'b1;
                    status_next = STATUS_NOT_MAPPED;
                    state_next  = ST_IDLE;
                end
                else if (level_reg == 2'd0)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                    if ((op_reg == OP_LOOKUP_USER) && !ram_rdata[PTE_U])
                    begin
                        status_next = STATUS_NOT_USER;
                    end
                    else
                    begin
                        status_next = STATUS_OK;
                        pa_next     = {ram_rdata[PTE_PPN_LSB +: PPN_W],
                                       (op_reg == OP_LOOKUP_OFFSET) ?
                                       va_reg[OFFSET_W-1:0] : {OFFSET_W{1'b0}}};
                    end
                end
                else if (!in_store)
                begin
                    done_next   = 1'b1;
                    status_next = STATUS_OUTSIDE;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    level_next = level_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            level_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            level_reg <= level_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        va_reg     <= va_next;
        pa_reg     <= pa_next;
        status_reg <= status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_ppn_reg       <= '0;
            store_base_ppn_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_ROOT_PPN)
            begin
                root_ppn_reg <= cfg_data[PPN_W-1:0];
            end
            else if (cfg_index == CFG_STORE_BASE_PPN)
            begin
                store_base_ppn_reg <= cfg_data[PPN_W-1:0];
            end
        end
    end

    a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != STATUS_OK)) |-> (phys_addr == '0))
        else $error("Failed transaction reports a nonzero physical address.");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status <= STATUS_OUTSIDE))
        else $error("Status code out of range.");

    a_no_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> !ram_we)
        else $error("Table RAM written during a walk.");

    a_too_large: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op != OP_WRITE) && (vaddr[VA_W-1:VA_LIMIT_BIT] != '0))
        |=> (done && (status == STATUS_TOO_LARGE)))
        else $error("Oversized address not rejected in the next cycle.");

endmodule

`default_nettype wire
